// ===== sv/dss_pkg.sv =====
// Shared types and constants for the disk scan scheduler.
package dss_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CYL_W        = 16;
    localparam int TOTAL_W      = 17;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // Register index within the APB map (paddr[2] selects the word)
    localparam logic REG_SWEEP_RIGHT = 1'b0;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic               command;
        logic [CYL_W-1:0]   request_cylinder;
        logic [CYL_W-1:0]   head_cylinder;
    } in_word_t;

    typedef struct packed {
        logic [CYL_W-1:0]   served_cylinder;
        logic [TOTAL_W-1:0] seek_total;
        logic               last;
    } out_word_t;

endpackage

// ===== sv/disk_scan_scheduler.sv =====
// Top level of the disk scan scheduler: sequencer, request store and APB register.
// Load words insert one cylinder into a sorted RAM list by shifting larger entries up
// one place; each shift is a RAM read, then a compare and write, and a closing write
// places the new word, so a load holds in_stall high until the word is in place,
// and a load into a full list is dropped. A start word first gives the head result,
// then walks the list through the single RAM read port, once per sweep direction,
// stopping once the last request is out; the walk also waits while the output is
// stalled. One word is taken at a time; in_stall is high while a word is in work.
module disk_scan_scheduler #(
    parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  dss_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output dss_pkg::out_word_t           out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dss_pkg::PADDR_W-1:0]  paddr,
    input  logic [dss_pkg::PDATA_W-1:0]  pwdata,
    output logic [dss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_CMP,
        S_EMIT_HEAD,
        S_EMIT_RD,
        S_EMIT_CHK
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             emitted_reg, emitted_next;
    logic                         pass_reg, pass_next;
    logic [dss_pkg::CYL_W-1:0]    req_reg, req_next;
    logic [dss_pkg::CYL_W-1:0]    head_reg, head_next;
    logic [dss_pkg::CYL_W-1:0]    prev_reg, prev_next;
    logic                         sweep_reg;
    logic                         out_valid_reg, out_valid_next;
    dss_pkg::out_word_t           out_reg, out_next;

    logic                         ram_we, ram_re;
    logic [IDX_W-1:0]             ram_waddr, ram_raddr;
    logic [dss_pkg::CYL_W-1:0]    ram_wdata, ram_rdata;
    logic [dss_pkg::TOTAL_W-1:0]  total_new;

    logic                         out_free;
    logic                         ascending;
    logic                         qualifies;
    logic [CNT_W-1:0]             idx_dec;
    logic [CNT_W-1:0]             rd_pos;

    dss_ram #(
        .WIDTH (dss_pkg::CYL_W),
        .DEPTH (MAX_REQUESTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dss_seek_unit u_seek (
        .prev_cyl  (prev_reg),
        .cyl       (ram_rdata),
        .total_in  (out_reg.seek_total),
        .total_out (total_new)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = {{(dss_pkg::PDATA_W-1){1'b0}}, sweep_reg};

    // APB register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && paddr[2] == dss_pkg::REG_SWEEP_RIGHT)
        begin
            sweep_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        idx_dec   = idx_reg - CNT_ONE;
        // first pass runs in the sweep direction, second pass the other way
        ascending = (sweep_reg != pass_reg);
        rd_pos    = ascending ? idx_reg : (count_reg - CNT_ONE - idx_reg);
        if (sweep_reg)
        begin
            qualifies = pass_reg ? (ram_rdata < head_reg) : (ram_rdata >= head_reg);
        end
        else
        begin
            qualifies = pass_reg ? (ram_rdata > head_reg) : (ram_rdata <= head_reg);
        end

        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        emitted_next   = emitted_reg;
        pass_next      = pass_reg;
        req_next       = req_reg;
        head_next      = head_reg;
        prev_next      = prev_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = idx_dec[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command == dss_pkg::CMD_START)
                    begin
                        head_next  = in_data.head_cylinder;
                        state_next = S_EMIT_HEAD;
                    end
                    else if (count_reg < CNT_MAX)
                    begin
                        req_next   = in_data.request_cylinder;
                        idx_next   = count_reg;
                        state_next = S_LOAD_RD;
                    end
                end
            end

            S_LOAD_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = req_reg;
                    count_next = count_reg + CNT_ONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_LOAD_CMP;
                end
            end

            S_LOAD_CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata > req_reg)
                begin
                    // shift the larger entry up one place
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_dec;
                    state_next = S_LOAD_RD;
                end
                else
                begin
                    ram_wdata  = req_reg;
                    count_next = count_reg + CNT_ONE;
                    state_next = S_IDLE;
                end
            end

            S_EMIT_HEAD:
            begin
                if (out_free)
                begin
                    out_next.served_cylinder = head_reg;
                    out_next.seek_total      = '0;
                    out_next.last            = (count_reg == '0);
                    out_valid_next           = 1'b1;
                    prev_next                = head_reg;
                    emitted_next             = '0;
                    idx_next                 = '0;
                    pass_next                = 1'b0;
                    state_next               = (count_reg == '0) ? S_IDLE : S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rd_pos[IDX_W-1:0];
                state_next = S_EMIT_CHK;
            end

            S_EMIT_CHK:
            begin
                if (!qualifies || out_free)
                begin
                    if (qualifies)
                    begin
                        out_next.served_cylinder = ram_rdata;
                        out_next.seek_total      = total_new;
                        out_next.last            = (emitted_reg + CNT_ONE == count_reg);
                        out_valid_next           = 1'b1;
                        prev_next                = ram_rdata;
                        emitted_next             = emitted_reg + CNT_ONE;
                    end
                    if (emitted_next == count_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else if (idx_reg == count_reg - CNT_ONE)
                    begin
                        idx_next   = '0;
                        pass_next  = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_ONE;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            emitted_reg   <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            emitted_reg   <= emitted_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        head_reg <= head_next;
        prev_reg <= prev_next;
        out_reg  <= out_next;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("request count beyond capacity");

    a_emit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD || state_reg == S_EMIT_CHK) |-> emitted_reg < count_reg)
        else $error("emit walk ran past the held requests");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last) |-> (state_reg != S_EMIT_RD && state_reg != S_EMIT_CHK))
        else $error("walk still running after the last word");

endmodule

// ===== sv/dss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/dss_seek_unit.sv =====
// Seek arithmetic: absolute cylinder distance added to the running total.
module dss_seek_unit (
    input  logic [dss_pkg::CYL_W-1:0]   prev_cyl,
    input  logic [dss_pkg::CYL_W-1:0]   cyl,
    input  logic [dss_pkg::TOTAL_W-1:0] total_in,
    output logic [dss_pkg::TOTAL_W-1:0] total_out
);

    logic [dss_pkg::CYL_W-1:0] span;

    always_comb
    begin
        span      = (cyl > prev_cyl) ? (cyl - prev_cyl) : (prev_cyl - cyl);
        total_out = total_in + {{(dss_pkg::TOTAL_W-dss_pkg::CYL_W){1'b0}}, span};
    end

endmodule
